// ===== hdl/sib_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insert buffer package
// Request and status codes, stream field layout and the cell control type.
// ----------------------------------------------------------------------------
package sib_pkg;

    // Request kinds carried on s_tuser.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    // Status codes carried on m_tuser.
    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_REJECTED = 2'd1;
    localparam logic [1:0] STAT_DUMPED   = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // Result field widths and the layout of m_tdata.
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int POS_LSB   = VALUE_W;
    localparam int COUNT_LSB = VALUE_W + POS_W;
    localparam int PAD_W     = M_TDATA_W - COUNT_LSB - COUNT_W;

    // A dump sends at most this many beats.
    localparam int MAX_RESULTS = 32;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic ins;   // insert the broadcast value in order
        logic rot;   // rotate the occupied cells one place toward the head
    } sib_cell_ctl_t;

endpackage

// ===== hdl/sib_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted insert buffer cell
// One entry of the ordered chain: compares against the broadcast value and
// keeps its entry or takes the new value or the left, right or head entry.
// ----------------------------------------------------------------------------
module sib_cell
    import sib_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sib_cell_ctl_t                ctl,
    input  logic signed [DATA_WIDTH-1:0] ins_value,
    input  logic signed [DATA_WIDTH-1:0] left_value,
    input  logic                         left_gt,
    input  logic                         left_valid,
    input  logic signed [DATA_WIDTH-1:0] right_value,
    input  logic                         right_valid,
    input  logic signed [DATA_WIDTH-1:0] head_value,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic                         gt,
    output logic                         valid
);

    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;
    logic                         valid_reg;
    logic                         valid_next;

    // An empty cell counts as greater, so the marker is a thermometer code.
    assign gt    = !valid_reg || (value_reg > ins_value);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.ins) begin
            valid_next = left_valid;
            if (gt) begin
                value_next = left_gt ? left_value : ins_value;
            end
        end else if (ctl.rot && valid_reg) begin
            // The last occupied cell wraps around to the head entry.
            value_next = right_valid ? right_value : head_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/sorted_insert_buffer.sv =====
// ----------------------------------------------------------------------------
// Sorted insert buffer
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream. s_tuser selects insert or dump, and
// s_tdata carries the 32-bit signed value to insert. Results leave on the
// m_ stream: m_tuser holds the status, m_tdata the entry value, position
// and count, and m_tlast marks the final beat of each request.
// An insert is compared against every cell at once; the cells at and beyond
// the insertion point shift one place right in the same cycle. Its single
// status beat appears in the cycle after acceptance, so inserts run at one per
// cycle as long as the receiver keeps up. A full store rejects the value.
// A dump rotates the occupied cells toward the head, one cell per cycle while
// the receiver keeps up, and sends the head entry each step. The rotation
// restores the original order at the end; a dump emits at most 32 beats, and
// its first beat is registered after the state register enters the dump state.
// A dump of an empty store answers with one beat in the cycle after acceptance.
// Input is refused during a dump. When the receiver stalls, the output
// register holds its beat and the chain stops rotating until it is taken.
// Reset empties the store and clears the result channel's valid state.
// ----------------------------------------------------------------------------
module sorted_insert_buffer
    import sib_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [0:0]           s_tuser,   // [0] req_type
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] entry_value, [36:32] position,
                                            // [42:37] entry_count, [47:43] zero
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                 m_tlast    // is_last
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int MAX_OUT = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              idx_next;
    logic [CNT_W-1:0]              nout_reg;
    logic [CNT_W-1:0]              nout_next;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [STATUS_W-1:0]           m_status_reg;
    logic [STATUS_W-1:0]           m_status_next;
    logic [VALUE_W-1:0]            m_value_reg;
    logic [VALUE_W-1:0]            m_value_next;
    logic [POS_W-1:0]              m_pos_reg;
    logic [POS_W-1:0]              m_pos_next;
    logic [COUNT_W-1:0]            m_count_reg;
    logic [COUNT_W-1:0]            m_count_next;
    logic                          m_last_reg;
    logic                          m_last_next;

    logic                          out_free;
    logic                          accept;
    logic                          full;
    logic signed [DATA_WIDTH-1:0]  ins_value;
    sib_cell_ctl_t                 ctl;

    logic signed [DATA_WIDTH-1:0]  cell_value [CAPACITY];
    logic                          cell_gt    [CAPACITY];
    logic                          cell_valid [CAPACITY];

    // The output register is free when empty or being drained this cycle.
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign ins_value = DATA_WIDTH'($signed(s_tdata[VALUE_W-1:0]));

    assign ctl.ins = accept && (s_tuser[0] == REQ_INSERT) && !full;
    assign ctl.rot = (state_reg == S_DUMP) && out_free;

    // Chain of cells: cell 0 holds the smallest value.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_value;
        logic                         left_gt;
        logic                         left_valid;
        logic signed [DATA_WIDTH-1:0] right_value;
        logic                         right_valid;

        if (i == 0) begin : g_first
            assign left_value = ins_value;
            assign left_gt    = 1'b0;
            assign left_valid = 1'b1;
        end else begin : g_inner
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[0];
            assign right_valid = 1'b0;
        end else begin : g_body
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        sib_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .ins_value   (ins_value),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .left_valid  (left_valid),
            .right_value (right_value),
            .right_valid (right_valid),
            .head_value  (cell_value[0]),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .valid       (cell_valid[i])
        );
    end

    // Request sequencing and the result register.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        nout_next     = nout_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_pos_next    = m_pos_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;

        if (accept) begin
            m_value_next = '0;
            m_pos_next   = '0;
            m_last_next  = 1'b1;
            if (s_tuser[0] == REQ_INSERT) begin
                m_valid_next = 1'b1;
                if (full) begin
                    m_status_next = STAT_REJECTED;
                    m_count_next  = COUNT_W'(count_reg);
                end else begin
                    count_next    = count_reg + CNT_W'(1);
                    m_status_next = STAT_INSERTED;
                    m_count_next  = COUNT_W'(count_reg + CNT_W'(1));
                end
            end else if (count_reg == '0) begin
                m_valid_next  = 1'b1;
                m_status_next = STAT_EMPTY;
                m_count_next  = '0;
            end else begin
                state_next = S_DUMP;
                idx_next   = '0;
                nout_next  = (count_reg > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : count_reg;
            end
        end else if (ctl.rot) begin
            // Each rotation step presents the next entry at the head cell.
            if (idx_reg < nout_reg) begin
                m_valid_next  = 1'b1;
                m_status_next = STAT_DUMPED;
                m_value_next  = VALUE_W'(cell_value[0]);
                m_pos_next    = POS_W'(idx_reg);
                m_count_next  = COUNT_W'(count_reg);
                m_last_next   = (idx_reg == nout_reg - CNT_W'(1));
            end
            idx_next = idx_reg + CNT_W'(1);
            if (idx_reg == count_reg - CNT_W'(1)) begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            nout_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            nout_reg    <= nout_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_pos_reg    <= m_pos_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_count_reg, m_pos_reg, m_value_reg};

endmodule

// ===== hdl/sib_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted insert buffer checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sib_checker
    import sib_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic                 m_tlast
);

    // A stalled beat holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // An accepted insert is answered by a single final status beat next cycle.
    a_insert_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == REQ_INSERT) |=>
            m_tvalid && m_tlast
            && (m_tuser == STAT_INSERTED || m_tuser == STAT_REJECTED))
        else $error("insert not answered by a final status beat");

    // An empty-store answer is a final beat with all data fields zero.
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_EMPTY) |-> m_tlast && (m_tdata == '0))
        else $error("empty-store beat malformed");

    // A rejection only happens with the store at capacity.
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_REJECTED) |->
            m_tdata[COUNT_LSB +: COUNT_W] == COUNT_W'(CAPACITY))
        else $error("rejection reported with store not full");

endmodule

bind sorted_insert_buffer sib_checker #(
    .CAPACITY (CAPACITY)
) u_sib_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sorted_insert_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted insert buffer testbench
// Drives insert and dump requests into the buffer on the s_ stream. It keeps
// its own sorted copy of the store to predict every result beat on the m_
// stream, and compares each beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_insert_buffer_tb;
    import sib_pkg::*;

    localparam int STORE_DEPTH  = 32;
    localparam int ITEM_COUNT   = 160;
    localparam int QUIET_TAIL   = 30;     // the last requests run without idling
    localparam int SETTLE_TICKS = 48;     // longest dump plus a margin
    localparam int MAX_REPORTS  = 10;

    // One request as the driver sees it. A request with hold_for_drain set is
    // not shown until every result beat predicted so far has come back.
    typedef struct {
        logic              req_type;
        logic signed [31:0] value;
        logic              hold_for_drain;
    } sib_request_t;

    // One result beat, unpacked into the fields of m_tdata, m_tuser and m_tlast.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic signed [31:0]  entry_value;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_last;
    } sib_beat_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [31:0] value
    logic [0:0]           s_tuser  = '0;    // [0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] entry_value, [36:32] position,
                                            // [42:37] entry_count, [47:43] zero
    logic [STATUS_W-1:0]  m_tuser;          // [1:0] status
    logic                 m_tlast;

    sib_request_t       request_q[$];      // requests still to be driven
    sib_beat_t          awaited_beats[$];  // predicted beats, oldest first
    logic signed [31:0] sorted_copy[$];    // our own ascending copy of the store

    logic        req_taken      = 1'b0;    // the shown request beat was accepted
    int unsigned send_gap_left  = 0;
    int unsigned recv_stall_left = 0;
    int unsigned accepted_reqs  = 0;
    int unsigned mismatch_count = 0;
    int unsigned tick_count     = 0;

    sorted_insert_buffer #(
        .CAPACITY   (STORE_DEPTH),
        .DATA_WIDTH (32)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Runs of idle cycles are allowed only while bit 8 of the tick count is clear,
    // so that long stretches with no idling at all occur as well, and never
    // once the tail of the request list is reached.
    function automatic bit idling_allowed();
        return (tick_count[8] == 1'b0) && (request_q.size() >= QUIET_TAIL);
    endfunction

    // Picks a value that mixes full-range noise, two bands around zero (the
    // narrow one makes equal values common) and the ends of the signed range.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 16)) - 32'sd8;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh8000_0001;
                    2: v = 32'sh7FFF_FFFE;
                    default: v = 32'sh7FFF_FFFF;
                endcase
            end
            default: v = $signed($urandom_range(0, 1000)) - 32'sd500;
        endcase
        return v;
    endfunction

    function automatic void queue_request(logic req_type, logic signed [31:0] value,
                                          logic hold_for_drain);
        sib_request_t r;
        r.req_type       = req_type;
        r.value          = value;
        r.hold_for_drain = hold_for_drain;
        request_q.push_back(r);
    endfunction

    function automatic void push_beat(logic [STATUS_W-1:0] status,
                                      logic signed [31:0] entry_value,
                                      logic [POS_W-1:0] position,
                                      logic [COUNT_W-1:0] entry_count,
                                      logic is_last);
        sib_beat_t b;
        b.status      = status;
        b.entry_value = entry_value;
        b.position    = position;
        b.entry_count = entry_count;
        b.is_last     = is_last;
        awaited_beats.push_back(b);
    endfunction

    // Applies one accepted request to the sorted copy and queues the beats
    // that it must produce.
    function automatic void apply_request(logic req_type, logic signed [31:0] value);
        int slot;
        int n;
        if (req_type == REQ_INSERT) begin
            if (sorted_copy.size() >= STORE_DEPTH) begin
                // A full store turns the value away and stays as it was.
                push_beat(STAT_REJECTED, '0, '0, COUNT_W'(sorted_copy.size()), 1'b1);
            end else begin
                // The new value goes after every entry that is not greater,
                // which keeps equal values in arrival order.
                slot = 0;
                while (slot < sorted_copy.size() && !(sorted_copy[slot] > value))
                    slot++;
                sorted_copy.insert(slot, value);
                push_beat(STAT_INSERTED, '0, '0, COUNT_W'(sorted_copy.size()), 1'b1);
            end
        end else if (sorted_copy.size() == 0) begin
            push_beat(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
            n = (sorted_copy.size() < MAX_RESULTS) ? sorted_copy.size() : MAX_RESULTS;
            for (int i = 0; i < n; i++)
                push_beat(STAT_DUMPED, sorted_copy[i], POS_W'(i),
                          COUNT_W'(sorted_copy.size()), (i == n - 1));
        end
    endfunction

    // Compares one accepted result beat with the oldest prediction.
    function automatic void compare_result_beat();
        sib_beat_t want;
        logic      bad;
        if (awaited_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result beat: status %0d value %0d pos %0d count %0d last %b",
                         m_tuser, $signed(m_tdata[31:0]), m_tdata[POS_LSB +: POS_W],
                         m_tdata[COUNT_LSB +: COUNT_W], m_tlast);
            return;
        end
        want = awaited_beats.pop_front();
        bad  = (m_tuser !== want.status)
            || (m_tdata[31:0] !== want.entry_value)
            || (m_tdata[POS_LSB +: POS_W] !== want.position)
            || (m_tdata[COUNT_LSB +: COUNT_W] !== want.entry_count)
            || (m_tdata[M_TDATA_W-1 -: PAD_W] !== '0)
            || (m_tlast !== want.is_last);
        if (bad) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $write("result mismatch: expected status %0d value %0d pos %0d count %0d last %b, ",
                       want.status, want.entry_value, want.position, want.entry_count,
                       want.is_last);
                $display("got status %0d value %0d pos %0d count %0d last %b pad %h",
                         m_tuser, $signed(m_tdata[31:0]),
                         m_tdata[POS_LSB +: POS_W], m_tdata[COUNT_LSB +: COUNT_W],
                         m_tlast, m_tdata[M_TDATA_W-1 -: PAD_W]);
            end
        end
    endfunction

    // Monitor: everything is sampled at the rising edge, before the block's
    // own registers move. Result beats are checked before the request of the
    // same edge is predicted, since no request answers in its own cycle.
    always @(posedge aclk) begin
        tick_count <= tick_count + 1;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                compare_result_beat();
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser[0], $signed(s_tdata));
                accepted_reqs++;
            end
        end
    end

    // Request driver: changes the s_ signals at the falling edge. A shown beat
    // stays put until the monitor has seen it accepted; after that the next
    // request goes out at once, or after a random gap, or, for a request
    // marked hold_for_drain, once every predicted beat has been received.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_taken) begin
            // Keep showing the same beat.
        end else if (send_gap_left > 0) begin
            send_gap_left--;
            s_tvalid <= 1'b0;
        end else if (request_q.size() > 0
                     && !(request_q[0].hold_for_drain && awaited_beats.size() != 0)) begin
            s_tdata  <= request_q[0].value;
            s_tuser  <= request_q[0].req_type;
            s_tvalid <= 1'b1;
            void'(request_q.pop_front());
            if (idling_allowed() && $urandom_range(0, 5) == 0)
                send_gap_left = $urandom_range(1, 17);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: m_tready drops in bursts of random length.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_stall_left > 0) begin
            recv_stall_left--;
            m_tready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
            recv_stall_left = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned total_reqs;
        int unsigned drain_at;

        // Directed part: a dump of the empty store, the ends of the signed
        // range, zero and its neighbors, repeated values, and dumps in
        // between. Most dumps carry nonzero values that must be ignored.
        queue_request(REQ_DUMP,   32'shFFFF_FFFF, 1'b0);
        queue_request(REQ_INSERT, 32'sd0,          1'b0);
        queue_request(REQ_INSERT, 32'sh7FFF_FFFF,  1'b0);
        queue_request(REQ_INSERT, 32'sh8000_0000,  1'b0);
        queue_request(REQ_INSERT, -32'sd1,         1'b0);
        queue_request(REQ_INSERT, 32'sd1,          1'b0);
        queue_request(REQ_DUMP,   32'sh5555_5555,  1'b0);
        queue_request(REQ_INSERT, 32'sd0,          1'b0);
        queue_request(REQ_INSERT, 32'sh7FFF_FFFF,  1'b0);
        queue_request(REQ_INSERT, 32'sh8000_0000,  1'b0);
        queue_request(REQ_INSERT, 32'sh5555_5555,  1'b0);
        queue_request(REQ_INSERT, 32'shAAAA_AAAA,  1'b0);
        queue_request(REQ_DUMP,   32'sh0000_0000,  1'b0);

        // Random part. Inserts dominate at first so the store fills up and
        // the full-store rejection is reached; dumps of a growing and then
        // full store are mixed in throughout. One request in the middle waits
        // for the output to drain completely before it is shown.
        drain_at = $urandom_range(40, 90);
        for (int i = request_q.size(); i < ITEM_COUNT; i++) begin
            if ($urandom_range(0, 9) < ((i < 70) ? 7 : 5))
                queue_request(REQ_INSERT, pick_value(), (i == drain_at));
            else
                queue_request(REQ_DUMP, $urandom, (i == drain_at));
        end
        total_reqs = request_q.size();

        // Reset is held low and released at a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (accepted_reqs < total_reqs || awaited_beats.size() != 0)
            @(posedge aclk);
        // Let any stray beat show up before the verdict.
        repeat (SETTLE_TICKS) @(posedge aclk);

        if (mismatch_count == 0 && awaited_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, where every request is a
    // full dump and every beat waits out the longest receiver stall.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
